### design/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with a synchronous reset disable.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define SCVR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Consequent checked in the cycle after the antecedent
`define SCVR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

### design/scvr_pkg.sv
// -----------------------------------------------------------------------------
// S-curve velocity ramp package
// Widths, reset values, register indexes, phase codes and word layouts.
// -----------------------------------------------------------------------------
package scvr_pkg;

   // ramp length in ticks, kept a power of two so the increment is a shift
   localparam int RAMP_SHIFT = 4;
   localparam int RAMP_STEPS = 1 << RAMP_SHIFT;
   localparam int TRI_SUM    = RAMP_STEPS * (RAMP_STEPS + 1) / 2;

   // Q8.16 velocity, 25-bit acceleration, signed work width for compares
   localparam int FRAC_W = 16;
   localparam int VEL_W  = 24;
   localparam int ACC_W  = 25;
   localparam int CW     = 2 * RAMP_SHIFT + VEL_W + 2;

   // serial divider: 32-bit dividend, one quotient bit per cycle
   localparam int DIV_W     = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   // gap*10/(22*N) == floor(floor(gap*5/N)/11)
   localparam int PEAK_DEN  = 11;

   // reset values
   localparam logic [VEL_W-1:0] PEAK_RESET       = VEL_W'(20 << FRAC_W);
   localparam logic [7:0]       SPEED_STEP_RESET = 8'd20;
   localparam logic [7:0]       VEL_LIMIT_RESET  = 8'd200;
   localparam logic [15:0]      PERIOD_NUM_RESET = 16'd4000;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SPEED_STEP = 2'd0,
      CSR_VEL_LIMIT  = 2'd1,
      CSR_PERIOD_NUM = 2'd2
   } csr_addr_type;

   // motion mode: only stop is special, every other code runs
   localparam logic [1:0] MODE_STOP = 2'd1;

   typedef enum logic [1:0] {
      PH_RISE = 2'd0,
      PH_HOLD = 2'd1,
      PH_FALL = 2'd2,
      PH_IDLE = 2'd3
   } phase_type;

   // word layouts
   localparam int REQ_W        = 8;
   localparam int RSP_W        = 48;
   localparam int RSP_PHASE_LSB = 24;
   localparam int RSP_EN_BIT    = 26;
   localparam int RSP_PER_LSB   = 27;

   // zero-extend an unsigned value into the signed work width
   function automatic logic signed [CW-1:0] to_cw(input logic [ACC_W-1:0] x);
      return $signed({{(CW-ACC_W){1'b0}}, x});
   endfunction

endpackage

### design/s_curve_velocity_ramp_top.sv
// -----------------------------------------------------------------------------
// S-curve velocity ramp
// Jerk-limited velocity ramp with a bit-serial divider for the peak
// acceleration and the step timer period.
// -----------------------------------------------------------------------------
// Usage:
//   req_*  : one word per ramp tick, tdata = {speed_level[5:2], motion_mode[1:0]}.
//   rsp_*  : one word per tick: velocity, ramp phase, motor enable, timer period;
//            tuser flags a newly computed period (period field is 0 otherwise).
//   csr_*  : register writes, taken at any edge with csr_we high; write only
//            while no tick is in flight.
// Sequence:
//   A tick runs ST_CALC after acceptance, then ST_PEAK when a move starts (peak
//   acceleration divide) and ST_PER when a new period is computed, then ST_DONE,
//   which loads the result register; only then is ready high again. The shared
//   one-bit-per-cycle restoring divider serves both divides.
// Reset:
//   Synchronous; clears the ramp to idle at zero velocity and restores the
//   register defaults (step 20, limit 200, numerator 4000).
// Stall:
//   The result register holds its word while rsp_tready is low; the core still
//   takes and works one more tick and waits to hand it over.
// -----------------------------------------------------------------------------
module s_curve_velocity_ramp_top (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: motion_mode[1:0], speed_level[5:2], zero fill
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [scvr_pkg::REQ_W-1:0]       req_tdata,
   // tdata: velocity[23:0], ramp_phase[25:24], motor_enable[26],
   //        timer_period[42:27], zero fill
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [scvr_pkg::RSP_W-1:0]       rsp_tdata,
   // tuser: period_valid[0]
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [scvr_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [scvr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import scvr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CALC = 5'b00010,
      ST_PEAK = 5'b00100,
      ST_PER  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type            state_ff, state_in;

   // latched tick fields
   logic [1:0]           mode_ff, mode_in;
   logic [3:0]           level_ff, level_in;

   // registers
   logic [7:0]           speed_step_ff, speed_step_in;
   logic [7:0]           vel_limit_ff, vel_limit_in;
   logic [15:0]          period_num_ff, period_num_in;

   // ramp state
   logic [VEL_W-1:0]     vel_ff, vel_in;
   logic [VEL_W-1:0]     last_vel_ff, last_vel_in;
   logic [ACC_W-1:0]     accel_ff, accel_in;
   logic [VEL_W-1:0]     peak_ff, peak_in;
   logic                 dir_down_ff, dir_down_in;
   phase_type            phase_ff, phase_in;
   logic                 driver_on_ff, driver_on_in;
   logic                 need_per_ff, need_per_in;
   logic [15:0]          period_ff, period_in;

   // serial divider
   logic [VEL_W-1:0]     div_rem_ff, div_rem_in;
   logic [DIV_W-1:0]     div_quo_ff, div_quo_in;
   logic [VEL_W-1:0]     div_den_ff, div_den_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [VEL_W:0]       div_trial;
   logic                 div_qbit;
   logic [VEL_W-1:0]     div_rem_step;
   logic [DIV_W-1:0]     div_quo_step;

   // output register
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic                 rsp_tuser_ff, rsp_tuser_in;

   // one ramp step results
   logic [VEL_W-1:0]     c_vel;
   logic [ACC_W-1:0]     c_acc;
   phase_type            c_phase;
   logic                 c_dir;
   logic                 c_start;
   logic                 c_drv;
   logic [VEL_W-1:0]     c_last;
   logic                 c_per;
   logic [DIV_W-1:0]     c_peak_num;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // one restoring divide step: shift in the next dividend bit, trial subtract
   always_comb begin : div_step
      div_trial    = {div_rem_ff, div_quo_ff[DIV_W-1]};
      div_qbit     = (div_trial >= {1'b0, div_den_ff});
      div_rem_step = div_qbit ? VEL_W'(div_trial - {1'b0, div_den_ff})
                              : div_trial[VEL_W-1:0];
      div_quo_step = {div_quo_ff[DIV_W-2:0], div_qbit};
   end

   // one ramp tick: target, phase step, peak dividend, clamp, driver logic
   always_comb begin : ramp_step
      logic [11:0]           prod;
      logic [7:0]            tgt_int;
      logic [VEL_W-1:0]      inc;
      logic [CW-1:0]         brake_u;
      logic signed [CW-1:0]  brake_s;
      logic signed [CW-1:0]  tgt_s;
      logic signed [CW-1:0]  lim_s;
      logic signed [CW-1:0]  v0;
      logic signed [CW-1:0]  v;
      logic signed [CW-1:0]  gap_s;
      logic [VEL_W+2:0]      gap5;

      // target velocity
      prod = 12'(level_ff) * 12'(speed_step_ff);
      if (mode_ff == MODE_STOP) begin
         tgt_int = '0;
      end else if (prod > {4'b0, vel_limit_ff}) begin
         tgt_int = vel_limit_ff;
      end else begin
         tgt_int = prod[7:0];
      end
      tgt_s = to_cw({1'b0, tgt_int, {FRAC_W{1'b0}}});
      lim_s = to_cw({1'b0, vel_limit_ff, {FRAC_W{1'b0}}});

      inc     = peak_ff >> RAMP_SHIFT;
      brake_u = (CW'(peak_ff) << RAMP_SHIFT) - (CW'(inc) * CW'(TRI_SUM));
      brake_s = $signed(brake_u);
      v0      = to_cw({1'b0, vel_ff});
      v       = v0;

      c_acc   = accel_ff;
      c_phase = phase_ff;
      c_dir   = dir_down_ff;
      c_start = 1'b0;

      unique case (phase_ff)
         PH_RISE: begin
            c_acc = accel_ff + ACC_W'(inc);
            if (c_acc >= {1'b0, peak_ff}) c_phase = PH_HOLD;
            v = dir_down_ff ? v0 - to_cw(c_acc) : v0 + to_cw(c_acc);
         end
         PH_HOLD: begin
            v = dir_down_ff ? v0 - to_cw(accel_ff) : v0 + to_cw(accel_ff);
            if (!dir_down_ff && (v >= tgt_s - brake_s)) begin
               c_phase = PH_FALL;
            end else if (dir_down_ff && (v <= tgt_s + brake_s)) begin
               c_phase = PH_FALL;
            end
         end
         PH_FALL: begin
            if (accel_ff <= ACC_W'(inc)) c_acc = '0;
            else c_acc = accel_ff - ACC_W'(inc);
            v = dir_down_ff ? v0 - to_cw(c_acc) : v0 + to_cw(c_acc);
            if (c_acc == '0) begin
               c_phase = PH_IDLE;
               v       = tgt_s;
            end
            // overshoot is cut back to the target
            if (!dir_down_ff && (v > tgt_s)) begin
               v       = tgt_s;
               c_phase = PH_IDLE;
            end else if (dir_down_ff && (v < tgt_s)) begin
               v       = tgt_s;
               c_phase = PH_IDLE;
            end
         end
         PH_IDLE: begin
            // a new move starts whenever the target moved away
            if (v0 != tgt_s) begin
               c_start = 1'b1;
               c_acc   = '0;
               c_phase = PH_RISE;
               c_dir   = (v0 < tgt_s) ? 1'b0 : 1'b1;
            end
         end
      endcase

      // peak dividend floor(gap*5/N), divided by 11 in the serial unit
      gap_s      = (v0 > tgt_s) ? v0 - tgt_s : tgt_s - v0;
      gap5       = {3'b0, gap_s[VEL_W-1:0]} + {1'b0, gap_s[VEL_W-1:0], 2'b0};
      c_peak_num = DIV_W'(gap5 >> RAMP_SHIFT);

      // clamp to [0, limit]
      if (v > lim_s) v = lim_s;
      else if (v[CW-1]) v = '0;
      c_vel = v[VEL_W-1:0];

      // driver enable and period request
      c_drv  = driver_on_ff;
      c_last = last_vel_ff;
      c_per  = 1'b0;
      if (!driver_on_ff && (c_vel != '0)) begin
         c_drv = 1'b1;
      end else if (driver_on_ff && (c_vel == '0)) begin
         c_drv = 1'b0;
      end else if ((c_vel != last_vel_ff) && (c_vel != '0)) begin
         c_last = c_vel;
         c_per  = 1'b1;
      end
   end

   // sequencer, register writes and output register
   always_comb begin : next_state
      state_in      = state_ff;
      mode_in       = mode_ff;
      level_in      = level_ff;
      speed_step_in = speed_step_ff;
      vel_limit_in  = vel_limit_ff;
      period_num_in = period_num_ff;
      vel_in        = vel_ff;
      last_vel_in   = last_vel_ff;
      accel_in      = accel_ff;
      peak_in       = peak_ff;
      dir_down_in   = dir_down_ff;
      phase_in      = phase_ff;
      driver_on_in  = driver_on_ff;
      need_per_in   = need_per_ff;
      period_in     = period_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_den_in    = div_den_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SPEED_STEP: speed_step_in = csr_wdata[7:0];
            CSR_VEL_LIMIT:  vel_limit_in  = csr_wdata[7:0];
            CSR_PERIOD_NUM: period_num_in = csr_wdata;
            default: ;
         endcase
      end

      // word taken downstream
      if (rsp_tready) rsp_tvalid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tdata[1:0];
               level_in = req_tdata[5:2];
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            vel_in       = c_vel;
            last_vel_in  = c_last;
            accel_in     = c_acc;
            phase_in     = c_phase;
            dir_down_in  = c_dir;
            driver_on_in = c_drv;
            need_per_in  = c_per;
            div_rem_in   = '0;
            div_cnt_in   = DIV_CNT_W'(DIV_W - 1);
            if (c_start) begin
               div_quo_in = c_peak_num;
               div_den_in = VEL_W'(PEAK_DEN);
               state_in   = ST_PEAK;
            end else if (c_per) begin
               div_quo_in = {period_num_ff, {FRAC_W{1'b0}}};
               div_den_in = c_vel;
               state_in   = ST_PER;
            end else begin
               state_in   = ST_DONE;
            end
         end
         ST_PEAK: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               // floor at RAMP_STEPS so the increment is at least one LSB
               if (div_quo_step < DIV_W'(RAMP_STEPS)) peak_in = VEL_W'(RAMP_STEPS);
               else peak_in = div_quo_step[VEL_W-1:0];
               if (need_per_ff) begin
                  div_rem_in = '0;
                  div_quo_in = {period_num_ff, {FRAC_W{1'b0}}};
                  div_den_in = vel_ff;
                  div_cnt_in = DIV_CNT_W'(DIV_W - 1);
                  state_in   = ST_PER;
               end else begin
                  state_in   = ST_DONE;
               end
            end
         end
         ST_PER: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               if (div_quo_step[DIV_W-1:16] != '0) period_in = '1;
               else period_in = div_quo_step[15:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{(RSP_W - RSP_PER_LSB - 16){1'b0}},
                                (need_per_ff ? period_ff : 16'd0),
                                driver_on_ff, phase_ff, vel_ff};
               rsp_tuser_in  = need_per_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and ramp state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         speed_step_ff <= SPEED_STEP_RESET;
         vel_limit_ff  <= VEL_LIMIT_RESET;
         period_num_ff <= PERIOD_NUM_RESET;
         vel_ff        <= '0;
         last_vel_ff   <= '0;
         accel_ff      <= '0;
         peak_ff       <= PEAK_RESET;
         dir_down_ff   <= 1'b0;
         phase_ff      <= PH_IDLE;
         driver_on_ff  <= 1'b0;
         need_per_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         speed_step_ff <= speed_step_in;
         vel_limit_ff  <= vel_limit_in;
         period_num_ff <= period_num_in;
         vel_ff        <= vel_in;
         last_vel_ff   <= last_vel_in;
         accel_ff      <= accel_in;
         peak_ff       <= peak_in;
         dir_down_ff   <= dir_down_in;
         phase_ff      <= phase_in;
         driver_on_ff  <= driver_on_in;
         need_per_ff   <= need_per_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      level_ff     <= level_in;
      period_ff    <= period_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_den_ff   <= div_den_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

endmodule

### design/scvr_checker.sv
// -----------------------------------------------------------------------------
// S-curve velocity ramp checker
// Port-level checks on the result channel, bound to the top level.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module scvr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [scvr_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       rsp_tuser
);
   import scvr_pkg::*;

   // a stalled word stays put
   `SCVR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // motor enable tracks nonzero velocity after each tick
   `SCVR_ASSERT_SAME(a_enable_vel, clock, reset, rsp_tvalid, rsp_tdata[RSP_EN_BIT] == (rsp_tdata[VEL_W-1:0] != '0))

   // no new period means a zero period field
   `SCVR_ASSERT_SAME(a_period_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[RSP_PER_LSB +: 16] == '0)

   // a new period only comes with a running motor
   `SCVR_ASSERT_SAME(a_period_run, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[RSP_EN_BIT] && (rsp_tdata[VEL_W-1:0] != '0))

endmodule

bind s_curve_velocity_ramp_top scvr_checker u_scvr_checker (.*);
